@@ rtl/htw_pkg.sv @@
// Shared constants, codes and node-store types of the tree-walk decoder.
package htw_pkg;

  localparam int MAX_NODES   = 512;
  localparam int STACK_DEPTH = 256;

  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int SADDR_W = $clog2(STACK_DEPTH);
  localparam int LVL_W   = $clog2(STACK_DEPTH + 1);
  localparam int SYM_W   = 8;
  localparam int BITS_PER_BYTE = 8;

  localparam logic [1:0] MODE_TREE    = 2'd0;
  localparam logic [1:0] MODE_DATA    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EARLY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_EXTRA = 2'd3;

  localparam logic [7:0] LEAF_MARKER = 8'd1;

  typedef struct packed {
    logic              leaf;
    logic [SYM_W-1:0]  sym;
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
  } node_t;

  typedef struct packed {
    logic              side;
    logic [NODE_W-1:0] parent;
  } stack_t;

  localparam int NODE_BITS  = $bits(node_t);
  localparam int STACK_BITS = $bits(stack_t);

endpackage

@@ rtl/htw_in_if.sv @@
// Input channel of the decoder: mode and data byte with valid and ready.
interface htw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

@@ rtl/htw_out_if.sv @@
// Result channel of the decoder: symbol, flags and status with valid and ready.
interface htw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       has_symbol;
  logic       last;
  logic [1:0] status;

  modport source (output valid, output symbol, output has_symbol, output last,
                  output status, input ready);
  modport sink (input valid, input symbol, input has_symbol, input last,
                input status, output ready);
endinterface

@@ rtl/htw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/huffman_tree_walk_decoder_top.sv @@
// Top level of the Huffman tree-walk decoder.
//
// The items channel carries a mode and a byte. Mode 0 feeds the code tree in
// pre-order, mode 1 feeds packed code bits LSB first, and mode 2 restarts for
// a new tree. The results channel carries one result per tree, restart or
// unused-mode item and per data byte sent before the tree is complete, and one
// result per decoded symbol for any other data byte, or a single empty result if
// the byte completes no symbol; last marks the final result of each item.
// The block works on one item at a time. A data byte is accepted, which starts
// the first node-store read; its code bits then drive a chain of dependent
// node-store reads, and the final result is handed over last. A tree byte may
// pass through a read-modify-write of the parent node and the parent stack
// and a push onto that stack before its result. Each result sits in an output
// register; a stalled receiver holds the walk at the next symbol until that
// register frees up, and no result is dropped.
// Reset clears the tree state and the output register. The node store and
// the parent stack are not cleared; only entries of a completed tree are
// ever walked.
module huffman_tree_walk_decoder_top (
  input  logic       clk,
  input  logic       rst,
  htw_in_if.sink     items,
  htw_out_if.source  results
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_TPAR, ST_TMOD, ST_TPUSH, ST_EMIT, ST_WBIT, ST_WEND
  } state_t;

  state_t state;

  logic [htw_pkg::CNT_W-1:0]  node_count;
  logic [htw_pkg::LVL_W-1:0]  level;
  logic                       awaiting;
  logic                       complete;
  logic [htw_pkg::NODE_W-1:0] pos;
  htw_pkg::node_t             cur_word;
  htw_pkg::node_t             root_word;
  logic [7:0]                 code_bits;
  logic [2:0]                 bit_idx;
  logic [htw_pkg::NODE_W-1:0] child;
  logic                       pend_valid;
  logic [7:0]                 pend_sym;
  logic [htw_pkg::NODE_W-1:0] new_idx;
  logic                       new_leaf;
  htw_pkg::stack_t            top;
  logic [1:0]                 res_status;

  logic                                 node_we;
  logic [htw_pkg::NODE_W-1:0]           node_waddr;
  htw_pkg::node_t                       node_wdata;
  logic                                 node_re;
  logic [htw_pkg::NODE_W-1:0]           node_raddr;
  logic [htw_pkg::NODE_BITS-1:0]        node_rdata;
  htw_pkg::node_t                       node_rd;

  logic                                 stk_we;
  logic [htw_pkg::SADDR_W-1:0]          stk_waddr;
  htw_pkg::stack_t                      stk_wdata;
  logic                                 stk_re;
  logic [htw_pkg::SADDR_W-1:0]          stk_raddr;
  logic [htw_pkg::STACK_BITS-1:0]       stk_rdata;
  htw_pkg::stack_t                      stk_rd;

  logic                       accept;
  logic                       out_free;
  logic                       out_load;
  logic                       node_room;
  logic                       stk_room;
  logic                       level_zero;
  logic                       leaf_wr;
  logic                       int_wr;
  logic [htw_pkg::SADDR_W-1:0] lvl_m1;
  htw_pkg::node_t             cur0;
  logic [htw_pkg::NODE_W-1:0] child0;
  logic                       leaf_hit;
  logic [7:0]                 hit_sym;
  htw_pkg::node_t             next_cur;
  logic [htw_pkg::NODE_W-1:0] child_nx;
  logic                       walk_stall;
  htw_pkg::node_t             parent_mod;

  function automatic logic [htw_pkg::NODE_W-1:0] pick(htw_pkg::node_t w, logic b);
    logic [htw_pkg::NODE_W-1:0] c;
    c = b ? w.right : w.left;
    if (htw_pkg::CNT_W'(c) >= htw_pkg::CNT_W'(htw_pkg::MAX_NODES)) begin
      c = '0;
    end
    return c;
  endfunction

  htw_ram #(
    .WIDTH (htw_pkg::NODE_BITS),
    .DEPTH (htw_pkg::MAX_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  htw_ram #(
    .WIDTH (htw_pkg::STACK_BITS),
    .DEPTH (htw_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign node_rd      = htw_pkg::node_t'(node_rdata);
  assign stk_rd       = htw_pkg::stack_t'(stk_rdata);
  assign items.ready  = (state == ST_IDLE);
  assign accept       = items.valid && items.ready;
  assign out_free     = !results.valid || results.ready;
  assign node_room    = node_count < htw_pkg::CNT_W'(htw_pkg::MAX_NODES);
  assign stk_room     = level < htw_pkg::LVL_W'(htw_pkg::STACK_DEPTH);
  assign level_zero   = (level == '0);
  assign lvl_m1       = htw_pkg::SADDR_W'(level - htw_pkg::LVL_W'(1));
  assign leaf_wr      = awaiting && node_room;
  assign int_wr       = !awaiting && (items.data_byte != htw_pkg::LEAF_MARKER) &&
                        node_room && stk_room;

  assign cur0       = (pos == '0) ? root_word : cur_word;
  assign child0     = pick(cur0, items.data_byte[0]);
  assign leaf_hit   = root_word.leaf || node_rd.leaf;
  assign hit_sym    = root_word.leaf ? root_word.sym : node_rd.sym;
  assign next_cur   = leaf_hit ? root_word : node_rd;
  assign child_nx   = pick(next_cur, code_bits[3'(bit_idx + 3'd1)]);
  assign walk_stall = leaf_hit && pend_valid && !out_free;
  assign out_load   = ((state == ST_EMIT || state == ST_WEND) && out_free) ||
                      (state == ST_WBIT && !walk_stall && leaf_hit && pend_valid);

  always_comb begin
    parent_mod = node_rd;
    if (top.side) begin
      parent_mod.right = new_idx;
    end else begin
      parent_mod.left = new_idx;
    end
  end

  always_comb begin
    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_re    = 1'b0;
    node_raddr = '0;
    stk_we     = 1'b0;
    stk_waddr  = '0;
    stk_wdata  = '0;
    stk_re     = 1'b0;
    stk_raddr  = lvl_m1;
    case (state)
      ST_IDLE: begin
        if (accept && items.mode == htw_pkg::MODE_TREE && !complete &&
            (leaf_wr || int_wr)) begin
          node_we    = 1'b1;
          node_waddr = node_count[htw_pkg::NODE_W-1:0];
          if (leaf_wr) begin
            node_wdata.leaf = 1'b1;
            node_wdata.sym  = items.data_byte;
          end
          stk_re = !level_zero;
        end
        if (accept && items.mode == htw_pkg::MODE_DATA && complete) begin
          node_re    = 1'b1;
          node_raddr = child0;
        end
      end
      ST_TPAR: begin
        node_re    = 1'b1;
        node_raddr = stk_rd.parent;
      end
      ST_TMOD: begin
        node_we    = 1'b1;
        node_waddr = top.parent;
        node_wdata = parent_mod;
        if (!top.side) begin
          stk_we         = 1'b1;
          stk_waddr      = lvl_m1;
          stk_wdata      = top;
          stk_wdata.side = 1'b1;
        end
      end
      ST_TPUSH: begin
        stk_we           = 1'b1;
        stk_waddr        = level[htw_pkg::SADDR_W-1:0];
        stk_wdata.side   = 1'b0;
        stk_wdata.parent = new_idx;
      end
      ST_WBIT: begin
        if (!walk_stall && bit_idx != 3'(htw_pkg::BITS_PER_BYTE - 1)) begin
          node_re    = 1'b1;
          node_raddr = child_nx;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we && node_waddr == '0) begin
      root_word <= node_wdata;
    end
    if (rst) begin
      state         <= ST_IDLE;
      node_count    <= '0;
      level         <= '0;
      awaiting      <= 1'b0;
      complete      <= 1'b0;
      pos           <= '0;
      pend_valid    <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (out_load) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (items.mode)
              htw_pkg::MODE_TREE: begin
                if (complete) begin
                  res_status <= htw_pkg::STATUS_EXTRA;
                  state      <= ST_EMIT;
                end else if (awaiting) begin
                  if (!node_room) begin
                    res_status <= htw_pkg::STATUS_FULL;
                    state      <= ST_EMIT;
                  end else begin
                    res_status <= htw_pkg::STATUS_OK;
                    node_count <= node_count + htw_pkg::CNT_W'(1);
                    awaiting   <= 1'b0;
                    new_idx    <= node_count[htw_pkg::NODE_W-1:0];
                    new_leaf   <= 1'b1;
                    if (level_zero) begin
                      complete <= 1'b1;
                      state    <= ST_EMIT;
                    end else begin
                      state <= ST_TPAR;
                    end
                  end
                end else if (items.data_byte == htw_pkg::LEAF_MARKER) begin
                  state <= ST_EMIT;
                  if (!node_room) begin
                    res_status <= htw_pkg::STATUS_FULL;
                  end else begin
                    res_status <= htw_pkg::STATUS_OK;
                    awaiting   <= 1'b1;
                  end
                end else if (!int_wr) begin
                  res_status <= htw_pkg::STATUS_FULL;
                  state      <= ST_EMIT;
                end else begin
                  res_status <= htw_pkg::STATUS_OK;
                  node_count <= node_count + htw_pkg::CNT_W'(1);
                  new_idx    <= node_count[htw_pkg::NODE_W-1:0];
                  new_leaf   <= 1'b0;
                  state      <= level_zero ? ST_TPUSH : ST_TPAR;
                end
              end
              htw_pkg::MODE_DATA: begin
                if (!complete) begin
                  res_status <= htw_pkg::STATUS_EARLY;
                  state      <= ST_EMIT;
                end else begin
                  code_bits  <= items.data_byte;
                  bit_idx    <= '0;
                  child      <= child0;
                  pend_valid <= 1'b0;
                  state      <= ST_WBIT;
                end
              end
              htw_pkg::MODE_RESTART: begin
                res_status <= htw_pkg::STATUS_OK;
                state      <= ST_EMIT;
                node_count <= '0;
                level      <= '0;
                awaiting   <= 1'b0;
                complete   <= 1'b0;
                pos        <= '0;
              end
              default: begin
                res_status <= htw_pkg::STATUS_OK;
                state      <= ST_EMIT;
              end
            endcase
          end
        end
        ST_TPAR: begin
          top   <= stk_rd;
          state <= ST_TMOD;
        end
        ST_TMOD: begin
          if (top.side) begin
            level <= level - htw_pkg::LVL_W'(1);
          end
          if (new_leaf) begin
            if (top.side && level == htw_pkg::LVL_W'(1)) begin
              complete <= 1'b1;
            end
            state <= ST_EMIT;
          end else begin
            state <= ST_TPUSH;
          end
        end
        ST_TPUSH: begin
          level <= level + htw_pkg::LVL_W'(1);
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            results.symbol     <= '0;
            results.has_symbol <= 1'b0;
            results.last       <= 1'b1;
            results.status     <= res_status;
            state              <= ST_IDLE;
          end
        end
        ST_WBIT: begin
          if (!walk_stall) begin
            if (leaf_hit) begin
              if (pend_valid) begin
                results.symbol     <= pend_sym;
                results.has_symbol <= 1'b1;
                results.last       <= 1'b0;
                results.status     <= htw_pkg::STATUS_OK;
              end
              pend_valid <= 1'b1;
              pend_sym   <= hit_sym;
              pos        <= '0;
            end else begin
              pos      <= child;
              cur_word <= node_rd;
            end
            if (bit_idx == 3'(htw_pkg::BITS_PER_BYTE - 1)) begin
              state <= ST_WEND;
            end else begin
              bit_idx <= bit_idx + 3'd1;
              child   <= child_nx;
            end
          end
        end
        ST_WEND: begin
          if (out_free) begin
            results.symbol     <= pend_valid ? pend_sym : 8'd0;
            results.has_symbol <= pend_valid;
            results.last       <= 1'b1;
            results.status     <= htw_pkg::STATUS_OK;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/htw_checker.sv @@
// Port-level assertions of the decoder top level, attached by a bind.
module htw_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] symbol,
  input logic       has_symbol
);

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("A new item was offered ready right after an accept.");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("A result was valid right after reset.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("A stalled result was withdrawn.");

  a_empty_result_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_symbol |-> symbol == 8'd0)
    else $error("A result without a symbol carried a nonzero symbol.");

endmodule

bind huffman_tree_walk_decoder_top htw_checker u_htw_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (items.valid),
  .in_ready   (items.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .symbol     (results.symbol),
  .has_symbol (results.has_symbol)
);

@@ bench/tb_top.sv @@
// Self-checking bench for the Huffman tree-walk decoder, checked against a built-in predictor.
module tb_top;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int ITEM_TARGET   = 420;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [7:0] symbol;
    logic       has_symbol;
    logic       last;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data;
    logic       typed;
    result_t    res;
  } row_t;

  localparam result_t UNTYPED    = '0;
  localparam result_t DONE_OK    = '{8'h00, 1'b0, 1'b1, htw_pkg::STATUS_OK};
  localparam result_t DONE_EARLY = '{8'h00, 1'b0, 1'b1, htw_pkg::STATUS_EARLY};
  localparam result_t DONE_EXTRA = '{8'h00, 1'b0, 1'b1, htw_pkg::STATUS_EXTRA};

  // Typed rows carry their single result; the others are checked against the predictor.
  row_t directed_rows [25] = '{
    '{htw_pkg::MODE_DATA,    8'hFF,                1'b1, DONE_EARLY},
    '{MODE_UNUSED,           8'hA5,                1'b1, DONE_OK},
    '{htw_pkg::MODE_TREE,    htw_pkg::LEAF_MARKER, 1'b1, DONE_OK},
    '{htw_pkg::MODE_TREE,    8'h5A,                1'b1, DONE_OK},
    '{htw_pkg::MODE_DATA,    8'h00,                1'b0, UNTYPED},
    '{htw_pkg::MODE_DATA,    8'hFF,                1'b0, UNTYPED},
    '{htw_pkg::MODE_TREE,    8'h33,                1'b1, DONE_EXTRA},
    '{htw_pkg::MODE_RESTART, 8'h00,                1'b1, DONE_OK},
    '{htw_pkg::MODE_DATA,    8'h3C,                1'b1, DONE_EARLY},
    '{htw_pkg::MODE_TREE,    8'h00,                1'b1, DONE_OK},
    '{htw_pkg::MODE_TREE,    htw_pkg::LEAF_MARKER, 1'b1, DONE_OK},
    '{htw_pkg::MODE_TREE,    8'h00,                1'b1, DONE_OK},
    '{htw_pkg::MODE_TREE,    8'hFF,                1'b1, DONE_OK},
    '{htw_pkg::MODE_TREE,    htw_pkg::LEAF_MARKER, 1'b1, DONE_OK},
    '{htw_pkg::MODE_TREE,    8'hFF,                1'b1, DONE_OK},
    '{htw_pkg::MODE_TREE,    htw_pkg::LEAF_MARKER, 1'b1, DONE_OK},
    '{htw_pkg::MODE_TREE,    8'h80,                1'b1, DONE_OK},
    '{htw_pkg::MODE_DATA,    8'h00,                1'b0, UNTYPED},
    '{htw_pkg::MODE_DATA,    8'hFF,                1'b0, UNTYPED},
    '{htw_pkg::MODE_DATA,    8'h5A,                1'b0, UNTYPED},
    '{htw_pkg::MODE_DATA,    8'h80,                1'b0, UNTYPED},
    '{htw_pkg::MODE_DATA,    8'h01,                1'b0, UNTYPED},
    '{htw_pkg::MODE_TREE,    htw_pkg::LEAF_MARKER, 1'b1, DONE_EXTRA},
    '{MODE_UNUSED,           8'hFF,                1'b1, DONE_OK},
    '{htw_pkg::MODE_RESTART, 8'hFF,                1'b1, DONE_OK}
  };

  logic clk;
  logic rst;
  htw_in_if  items ();
  htw_out_if results ();

  huffman_tree_walk_decoder_top u_top (
    .clk(clk),
    .rst(rst),
    .items(items),
    .results(results)
  );

  htw_pkg::node_t             tree_nodes [htw_pkg::MAX_NODES];
  htw_pkg::stack_t            open_parents [htw_pkg::STACK_DEPTH];
  int                         node_total;
  int                         open_level;
  logic                       want_symbol;
  logic                       tree_done;
  logic [htw_pkg::NODE_W-1:0] walk_node;
  result_t                    due_results [$];

  int   fails = 0;
  int   cycle_count = 0;
  int   hold_request = 0;
  int   sent_items = 0;
  logic calm = 1'b0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void clear_tree();
    node_total = 0;
    open_level = 0;
    want_symbol = 1'b0;
    tree_done = 1'b0;
    walk_node = '0;
  endfunction

  function automatic void queue_result(result_t r);
    due_results = {due_results, r};
  endfunction

  function automatic void attach_node(int idx);
    htw_pkg::stack_t top;
    if (open_level == 0) return;
    top = open_parents[open_level - 1];
    if (!top.side) begin
      tree_nodes[top.parent].left = htw_pkg::NODE_W'(idx);
      open_parents[open_level - 1].side = 1'b1;
    end else begin
      tree_nodes[top.parent].right = htw_pkg::NODE_W'(idx);
      open_level--;
    end
  endfunction

  function automatic logic [1:0] take_tree_byte(logic [7:0] b);
    htw_pkg::node_t  fresh;
    htw_pkg::stack_t entry;
    if (tree_done) return htw_pkg::STATUS_EXTRA;
    if (want_symbol) begin
      if (node_total >= htw_pkg::MAX_NODES) return htw_pkg::STATUS_FULL;
      fresh = '0;
      fresh.leaf = 1'b1;
      fresh.sym = b;
      tree_nodes[node_total] = fresh;
      attach_node(node_total);
      node_total++;
      want_symbol = 1'b0;
      if (open_level == 0) tree_done = 1'b1;
      return htw_pkg::STATUS_OK;
    end
    if (b == htw_pkg::LEAF_MARKER) begin
      if (node_total >= htw_pkg::MAX_NODES) return htw_pkg::STATUS_FULL;
      want_symbol = 1'b1;
      return htw_pkg::STATUS_OK;
    end
    if (node_total >= htw_pkg::MAX_NODES || open_level >= htw_pkg::STACK_DEPTH)
      return htw_pkg::STATUS_FULL;
    tree_nodes[node_total] = '0;
    attach_node(node_total);
    entry.side = 1'b0;
    entry.parent = htw_pkg::NODE_W'(node_total);
    open_parents[open_level] = entry;
    open_level++;
    node_total++;
    return htw_pkg::STATUS_OK;
  endfunction

  function automatic void predict_item(logic [1:0] mode, logic [7:0] b);
    result_t                    r;
    result_t                    hit;
    htw_pkg::node_t             cur;
    htw_pkg::node_t             reached;
    logic [htw_pkg::NODE_W-1:0] child;
    int                         found;
    r = '0;
    r.last = 1'b1;
    found = 0;
    if (mode == htw_pkg::MODE_DATA && tree_done) begin
      for (int i = 0; i < htw_pkg::BITS_PER_BYTE; i++) begin
        if (tree_nodes[0].leaf) begin
          reached = tree_nodes[0];
        end else begin
          cur = tree_nodes[walk_node];
          child = b[i] ? cur.right : cur.left;
          reached = tree_nodes[child];
          walk_node = child;
        end
        if (reached.leaf) begin
          hit = '0;
          hit.symbol = reached.sym;
          hit.has_symbol = 1'b1;
          queue_result(hit);
          walk_node = '0;
          found++;
        end
      end
      if (found == 0) queue_result(r);
      else due_results[due_results.size() - 1].last = 1'b1;
    end else begin
      case (mode)
        htw_pkg::MODE_TREE:    r.status = take_tree_byte(b);
        htw_pkg::MODE_DATA:    r.status = htw_pkg::STATUS_EARLY;
        htw_pkg::MODE_RESTART: clear_tree();
        default:               r.status = htw_pkg::STATUS_OK;
      endcase
      queue_result(r);
    end
  endfunction

  function automatic logic [7:0] internal_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == htw_pkg::LEAF_MARKER);
    return b;
  endfunction

  task automatic offer_row(row_t s);
    while (!calm && $urandom_range(99) < 12) begin
      items.valid <= 1'b0;
      @(posedge clk);
    end
    items.valid <= 1'b1;
    items.mode <= s.mode;
    items.data_byte <= s.data;
    do @(posedge clk); while (items.ready !== 1'b1);
    sent_items++;
    predict_item(s.mode, s.data);
    if (s.typed) begin
      due_results[due_results.size() - 1] = s.res;
    end
  endtask

  task automatic offer(logic [1:0] mode, logic [7:0] b);
    row_t s;
    s = '0;
    s.mode = mode;
    s.data = b;
    offer_row(s);
  endtask

  task automatic pause_until_drained();
    items.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // A left chain of internal nodes fills the parent stack, so further internal nodes are refused.
  task automatic fill_stack();
    offer(htw_pkg::MODE_RESTART, 8'h00);
    repeat (htw_pkg::STACK_DEPTH) offer(htw_pkg::MODE_TREE, internal_byte());
    offer(htw_pkg::MODE_TREE, 8'h00);
    offer(htw_pkg::MODE_TREE, htw_pkg::LEAF_MARKER);
    offer(htw_pkg::MODE_TREE, 8'($urandom_range(255)));
    offer(htw_pkg::MODE_TREE, 8'hFF);
    offer(htw_pkg::MODE_DATA, 8'($urandom_range(255)));
  endtask

  task automatic tree_session();
    int max_int;
    int pct;
    int open_slots;
    int n_int;
    max_int = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
    pct = $urandom_range(30, 85);
    offer(htw_pkg::MODE_RESTART, 8'($urandom_range(255)));
    open_slots = 1;
    n_int = 0;
    while (open_slots > 0) begin
      if ($urandom_range(19) == 0) offer(htw_pkg::MODE_DATA, 8'($urandom_range(255)));
      if (n_int < max_int && $urandom_range(99) < pct) begin
        offer(htw_pkg::MODE_TREE, internal_byte());
        n_int++;
        open_slots++;
      end else begin
        offer(htw_pkg::MODE_TREE, htw_pkg::LEAF_MARKER);
        offer(htw_pkg::MODE_TREE, 8'($urandom_range(255)));
        open_slots--;
      end
    end
    repeat ($urandom_range(2, 14)) begin
      case ($urandom_range(19))
        0: offer(htw_pkg::MODE_TREE, 8'($urandom_range(255)));
        1: offer(MODE_UNUSED, 8'($urandom_range(255)));
        default: offer(htw_pkg::MODE_DATA, 8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic noise_burst();
    logic [7:0] b;
    offer(htw_pkg::MODE_RESTART, 8'($urandom_range(255)));
    repeat ($urandom_range(3, 10)) begin
      b = ($urandom_range(9) < 3) ? htw_pkg::LEAF_MARKER : 8'($urandom_range(255));
      offer(2'($urandom_range(3)), b);
    end
  endtask

  initial begin
    result_t got;
    result_t want;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (results.valid === 1'b1 && results.ready === 1'b1) begin
        got.symbol = results.symbol;
        got.has_symbol = results.has_symbol;
        got.last = results.last;
        got.status = results.status;
        if (due_results.size() == 0) begin
          fails++;
          $display("%0t: expected no result, got sym %h has %b last %b status %0d",
                   $time, got.symbol, got.has_symbol, got.last, got.status);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: expected sym %h has %b last %b status %0d, %s %h %b %b %0d",
                     $time, want.symbol, want.has_symbol, want.last, want.status,
                     "got", got.symbol, got.has_symbol, got.last, got.status);
          end
        end
      end
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    results.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        results.ready <= 1'b0;
      end else begin
        results.ready <= calm || $urandom_range(99) >= 12;
      end
    end
  end

  initial begin
    int round;
    items.valid = 1'b0;
    items.mode = htw_pkg::MODE_TREE;
    items.data_byte = 8'h00;
    rst = 1'b1;
    for (int i = 0; i < htw_pkg::MAX_NODES; i++) tree_nodes[i] = '0;
    for (int i = 0; i < htw_pkg::STACK_DEPTH; i++) open_parents[i] = '0;
    clear_tree();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) offer_row(directed_rows[i]);
    pause_until_drained();

    // The receiver holds off while a single-leaf tree floods the output.
    offer(htw_pkg::MODE_RESTART, 8'($urandom_range(255)));
    offer(htw_pkg::MODE_TREE, htw_pkg::LEAF_MARKER);
    offer(htw_pkg::MODE_TREE, 8'($urandom_range(255)));
    calm = 1'b1;
    hold_request = HOLD_CYCLES;
    repeat (30) offer(htw_pkg::MODE_DATA, 8'($urandom_range(255)));
    calm = 1'b0;
    pause_until_drained();

    fill_stack();
    pause_until_drained();

    round = 0;
    while (sent_items < ITEM_TARGET) begin
      calm = (round == 1);
      if ($urandom_range(99) < 85) tree_session();
      else noise_burst();
      if ($urandom_range(9) == 0) pause_until_drained();
      round++;
    end
    calm = 1'b0;

    items.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
